// ----- rtl/pfa_pkg.sv -----
`default_nettype none

package pfa_pkg;

    // default sizing
    localparam int NUM_FRAMES_DEF = 16384;
    localparam int COUNT_BITS_DEF = 16;

    // field widths
    localparam int OPCODE_W   = 3;
    localparam int FRAME_W    = 14;
    localparam int STATUS_W   = 3;
    localparam int REFCNT_W   = 16;
    localparam int S_TDATA_W  = 16;  // frame, padded to bytes
    localparam int M_TDATA_W  = 32;  // alloc_frame, ref_count, padded to bytes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // config register widths and reset values
    localparam int TOTAL_W    = 15;
    localparam int RESERVED_W = 15;
    localparam int SKIP_W     = 14;
    localparam logic [TOTAL_W-1:0]    TOTAL_RST    = 15'd16384;
    localparam logic [RESERVED_W-1:0] RESERVED_RST = 15'd0;
    localparam logic [SKIP_W-1:0]     SKIP_RST     = 14'd0;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_EN  = 2'd3;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_INIT   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_ALLOC  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_FREE   = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_INCREF = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_DECREF = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_READ   = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LIMIT     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DBL_FREE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_FRAME = 3'd4;

endpackage

`default_nettype wire

// ----- rtl/page_frame_allocator_refcount_core.sv -----
// Page frame allocator with a reference count per frame and a LIFO free list.
//
// Channels:
//   s-side  : one command per transaction. tuser = opcode, tdata = frame.
//   m-side  : one result per command. tuser = status, tdata = alloc_frame
//             and ref_count.
//   cfg     : register writes (total, reserved, skipped frame, skip enable),
//             always ready; write only while no command is in flight.
// Sequencing:
//   A command is accepted only while the sequencer is idle. Alloc, free,
//   incref, decref and read reach the result register after acceptance
//   by way of a synchronous read of the count, link and mark memories,
//   then an update of them. Init sweeps every frame in turn, writing its
//   count and mark and linking the frames it pushes; its result follows.
//   A new command is taken only once the last one has left the sequencer.
// Reset clears the sequencer, the list head and length, the result valid
// flag and the config registers. Counts and marks hold garbage until the
// first init. If the receiver stalls, the finished result waits in the
// output register; the next command can still be accepted and runs up to
// its update cycle, where it holds until the output register frees up.
`default_nettype none

module page_frame_allocator_refcount_core #(
    parameter int NUM_FRAMES = pfa_pkg::NUM_FRAMES_DEF,
    parameter int COUNT_BITS = pfa_pkg::COUNT_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // command stream
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [pfa_pkg::S_TDATA_W-1:0]     i_s_tdata,   // [13:0] frame, [15:14] pad
    input  wire logic [pfa_pkg::OPCODE_W-1:0]      i_s_tuser,   // [2:0] opcode
    // result stream
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [pfa_pkg::M_TDATA_W-1:0]          o_m_tdata,   // [13:0] alloc_frame,
                                                                // [29:14] ref_count,
                                                                // [31:30] zero
    output logic [pfa_pkg::STATUS_W-1:0]           o_m_tuser,   // [2:0] status
    // config write channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [pfa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [pfa_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    import pfa_pkg::*;

    localparam int FW  = $clog2(NUM_FRAMES);                       // frame index bits
    localparam int LW  = FW + 1;                                   // list length bits
    localparam int TW  = (LW > TOTAL_W) ? LW : TOTAL_W;            // compare width
    localparam int FAW = (FW > FRAME_W) ? FW : FRAME_W;
    localparam int CW  = COUNT_BITS;
    localparam int OW  = (CW > REFCNT_W) ? CW : REFCNT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_INIT = 3'd3;

    localparam logic [CW-1:0] CNT_MAX  = {CW{1'b1}};
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);
    localparam logic [FW-1:0] IDX_LAST = FW'(NUM_FRAMES - 1);
    localparam logic [TW-1:0] TW_NUM   = TW'(NUM_FRAMES);

    // config registers
    logic [TOTAL_W-1:0]    r_total;
    logic [RESERVED_W-1:0] r_reserved;
    logic [SKIP_W-1:0]     r_skipped;
    logic                  r_skip_en;

    // sequencer and list state
    logic [2:0]          r_state, n_state;
    logic [FW-1:0]       r_head, n_head;
    logic [LW-1:0]       r_len, n_len;
    logic [FW-1:0]       r_idx, n_idx;
    logic [OPCODE_W-1:0] r_op;
    logic [FRAME_W-1:0]  r_frame;
    logic [FW-1:0]       r_addr;

    // memories and their registered read data
    logic [CW-1:0] r_ref_mem  [NUM_FRAMES];
    logic [FW-1:0] r_lnk_mem  [NUM_FRAMES];
    logic          r_mark_mem [NUM_FRAMES];
    logic [CW-1:0] r_ref_q;
    logic [FW-1:0] r_lnk_q;
    logic          r_mark_q;

    // output register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [FRAME_W-1:0]  r_out_frame;
    logic [REFCNT_W-1:0] r_out_count;

    // combinational
    logic                w_go;
    logic [TW-1:0]       w_tot, w_res, w_tot_cfg, w_res_cfg;
    logic                w_init_push, w_bad;
    logic                w_ref_we, w_lnk_we, w_mark_we;
    logic [FW-1:0]       w_waddr;
    logic [CW-1:0]       w_ref_wd;
    logic [FW-1:0]       w_lnk_wd;
    logic                w_mark_wd;
    logic                w_out_load;
    logic [STATUS_W-1:0] w_status;
    logic [FRAME_W-1:0]  w_frame;
    logic [CW-1:0]       w_count;
    logic [FAW-1:0]      w_in_frame_ext, w_addr_ext;
    logic [OW-1:0]       w_count_ext;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tuser   = r_out_status;
    assign o_m_tdata   = {{(M_TDATA_W - REFCNT_W - FRAME_W){1'b0}}, r_out_count, r_out_frame};

    assign w_go = !r_out_valid || i_m_tready;

    // effective totals: total clipped to the memory depth, reserved to the total
    assign w_tot_cfg = TW'(r_total);
    assign w_res_cfg = TW'(r_reserved);
    assign w_tot     = (w_tot_cfg < TW_NUM) ? w_tot_cfg : TW_NUM;
    assign w_res     = (w_res_cfg < w_tot) ? w_res_cfg : w_tot;

    assign w_init_push = (TW'(r_idx) >= w_res) && (TW'(r_idx) < w_tot)
                         && !(r_skip_en && (TW'(r_idx) == TW'(r_skipped)));
    assign w_bad = (TW'(r_frame) >= w_tot);

    assign w_in_frame_ext = FAW'(i_s_tdata[FRAME_W-1:0]);
    assign w_addr_ext     = FAW'(r_addr);
    assign w_count_ext    = OW'(w_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= TOTAL_RST;
            r_reserved <= RESERVED_RST;
            r_skipped  <= SKIP_RST;
            r_skip_en  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TOTAL:    r_total    <= i_cfg_data[TOTAL_W-1:0];
                CFG_RESERVED: r_reserved <= i_cfg_data[RESERVED_W-1:0];
                CFG_SKIP:     r_skipped  <= i_cfg_data[SKIP_W-1:0];
                CFG_SKIP_EN:  r_skip_en  <= i_cfg_data[0];
                default:      ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_len      = r_len;
        n_idx      = r_idx;
        w_ref_we   = 1'b0;
        w_lnk_we   = 1'b0;
        w_mark_we  = 1'b0;
        w_waddr    = r_addr;
        w_ref_wd   = r_ref_q;
        w_lnk_wd   = r_head;
        w_mark_wd  = 1'b0;
        w_out_load = 1'b0;
        w_status   = ST_OK;
        w_frame    = r_frame;
        w_count    = '0;

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_s_tuser == OP_INIT) begin
                        n_state = S_INIT;
                        n_idx   = '0;
                        n_head  = '0;
                        n_len   = '0;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_INIT: begin
                // one frame per cycle, pushed frames chain to the previous head
                w_waddr   = r_idx;
                w_ref_we  = 1'b1;
                w_ref_wd  = (TW'(r_idx) < w_res) ? CNT_ONE : '0;
                w_mark_we = 1'b1;
                w_mark_wd = w_init_push;
                w_lnk_we  = w_init_push;
                if (w_init_push) begin
                    n_head = r_idx;
                    n_len  = r_len + LW'(1);
                end
                n_idx = r_idx + FW'(1);
                if (r_idx == IDX_LAST) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_go) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                    case (r_op)
                        OP_ALLOC: begin
                            if (r_len == '0) begin
                                w_status = ST_NO_FREE;
                                w_frame  = '0;
                            end else begin
                                w_mark_we = 1'b1;
                                w_mark_wd = 1'b0;
                                n_len     = r_len - LW'(1);
                                n_head    = (r_len == LW'(1)) ? '0 : r_lnk_q;
                                w_frame   = w_addr_ext[FRAME_W-1:0];
                                w_count   = r_ref_q;
                            end
                        end
                        OP_FREE, OP_INCREF, OP_DECREF, OP_READ: begin
                            if (w_bad) begin
                                w_status = ST_BAD_FRAME;
                            end else begin
                                w_count = r_ref_q;
                                if (r_op == OP_INCREF) begin
                                    if (r_ref_q == CNT_MAX) begin
                                        w_status = ST_LIMIT;
                                    end else begin
                                        w_ref_we = 1'b1;
                                        w_ref_wd = r_ref_q + CNT_ONE;
                                        w_count  = w_ref_wd;
                                    end
                                end else if (r_op == OP_DECREF) begin
                                    if (r_ref_q == '0) begin
                                        w_status = ST_LIMIT;
                                    end else begin
                                        w_ref_we = 1'b1;
                                        w_ref_wd = r_ref_q - CNT_ONE;
                                        w_count  = w_ref_wd;
                                    end
                                end
                                // release: free at zero, or decref down to zero
                                if ((r_op == OP_FREE && r_ref_q == '0)
                                    || (r_op == OP_DECREF && r_ref_q == CNT_ONE)) begin
                                    if (r_mark_q) begin
                                        w_status = ST_DBL_FREE;
                                    end else begin
                                        w_lnk_we  = 1'b1;
                                        w_lnk_wd  = r_head;
                                        w_mark_we = 1'b1;
                                        w_mark_wd = 1'b1;
                                        n_head    = r_addr;
                                        n_len     = r_len + LW'(1);
                                    end
                                end
                            end
                        end
                        default: ;  // init done, unused opcodes: echo only
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_len       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_len   <= n_len;
            r_idx   <= n_idx;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // command latch and result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_s_tvalid) begin
            r_op    <= i_s_tuser;
            r_frame <= i_s_tdata[FRAME_W-1:0];
            r_addr  <= (i_s_tuser == OP_ALLOC) ? r_head : w_in_frame_ext[FW-1:0];
        end
        if (w_out_load) begin
            r_out_status <= w_status;
            r_out_frame  <= w_frame;
            r_out_count  <= w_count_ext[REFCNT_W-1:0];
        end
    end

    // count, link and mark memories
    always_ff @(posedge i_clk) begin
        if (w_ref_we) begin
            r_ref_mem[w_waddr] <= w_ref_wd;
        end
        if (w_lnk_we) begin
            r_lnk_mem[w_waddr] <= w_lnk_wd;
        end
        if (w_mark_we) begin
            r_mark_mem[w_waddr] <= w_mark_wd;
        end
        if (r_state == S_READ) begin
            r_ref_q  <= r_ref_mem[r_addr];
            r_lnk_q  <= r_lnk_mem[r_addr];
            r_mark_q <= r_mark_mem[r_addr];
        end
    end

endmodule

`default_nettype wire

// ----- sim/page_frame_allocator_refcount_core_tb.sv -----
`timescale 1ns / 1ps

module page_frame_allocator_refcount_core_tb;
    import pfa_pkg::*;

    localparam int FRAMES = NUM_FRAMES_DEF;
    localparam logic [REFCNT_W-1:0] COUNT_TOP = '1;
    // opcodes with no function: the block must echo the frame and change nothing
    localparam logic [OPCODE_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE7 = 3'd7;
    // an init sweep runs over every frame with no transaction at all
    localparam int QUIET_LIMIT = 60000;
    localparam int MAX_PRINTS = 100;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FRAME_W-1:0]  frame;
        logic [REFCNT_W-1:0] count;
    } t_result;

    // one row of the directed table: a register write or a command
    typedef struct {
        bit                    is_reg;
        logic [OPCODE_W-1:0]   op;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] arg;
        t_result               res;
    } t_step;

    logic i_clk;
    logic i_rst_n = 1'b0;

    // command side, driven at the falling edge
    logic                  cmd_valid = 1'b0;
    logic [OPCODE_W-1:0]   cmd_op = OP_INIT;
    logic [FRAME_W-1:0]    cmd_frame = '0;
    bit                    cmd_fixed = 1'b0;   // use the typed-in result below
    t_result               cmd_fixed_res = '0;
    logic                  o_s_tready;

    // result side
    logic                  o_m_tvalid;
    logic                  res_ready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic [STATUS_W-1:0]   o_m_tuser;

    // register writes
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = CFG_TOTAL;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  o_cfg_ready;

    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned mismatches = 0;
    int unsigned quiet = 0;

    t_result due_results[$];
    t_step   dir_tab[$];

    // shadow of the allocator: counts, links, list marks, head and registers
    logic [REFCNT_W-1:0]   use_cnt [FRAMES];
    logic [FRAME_W-1:0]    link_to [FRAMES];
    bit                    listed  [FRAMES];
    logic [FRAME_W-1:0]    head_frame = '0;
    bit                    list_dry = 1'b1;
    int unsigned           list_len = 0;
    logic [TOTAL_W-1:0]    reg_total = TOTAL_RST;
    logic [RESERVED_W-1:0] reg_reserved = RESERVED_RST;
    logic [SKIP_W-1:0]     reg_skip = SKIP_RST;
    bit                    reg_skip_en = 1'b0;

    page_frame_allocator_refcount_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (cmd_valid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   ({2'b00, cmd_frame}),   // [13:0] frame, [15:14] pad
        .i_s_tuser   (cmd_op),               // [2:0] opcode
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (res_ready),
        .o_m_tdata   (o_m_tdata),            // [13:0] alloc_frame, [29:14] ref_count
        .o_m_tuser   (o_m_tuser),            // [2:0] status
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // ---------------------------------------------------------------- predictor

    // total_pages is clipped to the number of frames the block holds
    function automatic int unsigned frames_in_use();
        return (reg_total > FRAMES) ? FRAMES : int'(reg_total);
    endfunction

    function automatic void link_in(int unsigned f);
        link_to[f] = head_frame;
        head_frame = FRAME_W'(f);
        listed[f]  = 1'b1;
        list_len++;
        list_dry   = 1'b0;
    endfunction

    // a frame already on the list is a double free; otherwise push it
    function automatic logic [STATUS_W-1:0] hand_back(int unsigned f);
        if (listed[f]) return ST_DBL_FREE;
        link_in(f);
        return ST_OK;
    endfunction

    // init: reserved frames get count 1, the rest 0, and every other frame in use
    // (except the skipped one) goes on the list in rising order
    function automatic void sweep_frames();
        int unsigned tot;
        int unsigned res;
        tot = frames_in_use();
        res = (reg_reserved < tot) ? int'(reg_reserved) : tot;
        head_frame = '0;
        list_dry   = 1'b1;
        list_len   = 0;
        for (int unsigned f = 0; f < FRAMES; f++) begin
            listed[f] = 1'b0;
            if (f < res) begin
                use_cnt[f] = REFCNT_W'(1);
            end else begin
                use_cnt[f] = '0;
                if (f < tot && !(reg_skip_en && f == reg_skip)) link_in(f);
            end
        end
    endfunction

    function automatic t_result frame_alloc_step(input logic [OPCODE_W-1:0] op,
                                                 input logic [FRAME_W-1:0] fr);
        t_result r;
        int unsigned h;
        r.status = ST_OK;
        r.frame  = fr;
        r.count  = '0;
        case (op)
            OP_INIT: sweep_frames();
            OP_ALLOC: begin
                if (list_dry || list_len == 0) begin
                    r.status = ST_NO_FREE;
                    r.frame  = '0;
                end else begin
                    h = int'(head_frame);
                    listed[h] = 1'b0;
                    list_len--;
                    if (list_len == 0) begin
                        list_dry   = 1'b1;
                        head_frame = '0;
                    end else begin
                        head_frame = link_to[h];
                    end
                    r.frame = FRAME_W'(h);
                    r.count = use_cnt[h];
                end
            end
            OP_FREE, OP_INCREF, OP_DECREF, OP_READ: begin
                if (fr >= frames_in_use()) begin
                    r.status = ST_BAD_FRAME;
                end else begin
                    case (op)
                        OP_FREE: begin
                            // a frame still referenced is left alone
                            if (use_cnt[fr] == 0) r.status = hand_back(fr);
                        end
                        OP_INCREF: begin
                            if (use_cnt[fr] == COUNT_TOP) r.status = ST_LIMIT;
                            else use_cnt[fr] = use_cnt[fr] + 1'b1;
                        end
                        OP_DECREF: begin
                            if (use_cnt[fr] == 0) begin
                                r.status = ST_LIMIT;
                            end else begin
                                use_cnt[fr] = use_cnt[fr] - 1'b1;
                                if (use_cnt[fr] == 0) r.status = hand_back(fr);
                            end
                        end
                        default: ;
                    endcase
                    r.count = use_cnt[fr];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void set_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_TOTAL:    reg_total    = val[TOTAL_W-1:0];
            CFG_RESERVED: reg_reserved = val[RESERVED_W-1:0];
            CFG_SKIP:     reg_skip     = val[SKIP_W-1:0];
            CFG_SKIP_EN:  reg_skip_en  = val[0];
            default: ;
        endcase
    endfunction

    // -------------------------------------------------------------- scoreboard

    task automatic report(input string what, input logic [32:0] want, input logic [32:0] got);
        if (mismatches < MAX_PRINTS)
            $display("%0t ns: %s mismatch, want %0h got %0h", $time, what, want, got);
        mismatches++;
    endtask

    // results are checked before the command of the same edge is predicted;
    // one process keeps the queue order free of scheduling races
    always @(posedge i_clk) begin : scoreboard
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (o_m_tvalid === 1'b1 && res_ready) begin
                got.status = o_m_tuser;
                got.frame  = o_m_tdata[FRAME_W-1:0];
                got.count  = o_m_tdata[FRAME_W +: REFCNT_W];
                if (due_results.size() == 0) begin
                    report("unsolicited result", '0, got);
                end else begin
                    want = due_results.pop_front();
                    if (got.status !== want.status) report("status", want.status, got.status);
                    if (got.frame !== want.frame)   report("alloc_frame", want.frame, got.frame);
                    if (got.count !== want.count)   report("ref_count", want.count, got.count);
                end
            end
            if (cmd_valid && o_s_tready === 1'b1) begin
                want = frame_alloc_step(cmd_op, cmd_frame);
                due_results.push_back(cmd_fixed ? cmd_fixed_res : want);
            end
            if (cfg_valid && o_cfg_ready === 1'b1) set_reg(cfg_idx, cfg_data);
        end
    end

    // watchdog: cycles without any transaction on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_valid && o_s_tready === 1'b1) ||
            (o_m_tvalid === 1'b1 && res_ready) || (cfg_valid && o_cfg_ready === 1'b1))
            quiet = 0;
        else
            quiet++;
        if (quiet == QUIET_LIMIT) begin
            $display("[page_frame_allocator_refcount_core] ERROR");
            $finish;
        end
    end

    // result receiver, stalls at random
    always @(negedge i_clk) begin
        res_ready <= ($urandom_range(99) >= stall_pct);
    end

    // ------------------------------------------------------------------ drivers

    // all driver tasks start and end at a falling edge
    task automatic push_cmd(input logic [OPCODE_W-1:0] op, input logic [FRAME_W-1:0] fr,
                            input bit fixed, input t_result res);
        while ($urandom_range(99) < gap_pct) begin
            cmd_valid = 1'b0;
            @(negedge i_clk);
        end
        cmd_valid     = 1'b1;
        cmd_op        = op;
        cmd_frame     = fr;
        cmd_fixed     = fixed;
        cmd_fixed_res = res;
        @(posedge i_clk);
        while (o_s_tready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // hold commands until every result is back, then let the pipe empty
    task automatic settle();
        cmd_valid = 1'b0;
        while (due_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        settle();
        cfg_valid = 1'b1;
        cfg_idx   = idx;
        cfg_data  = val;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            1:       begin gap_pct = 46; stall_pct = 0;  end
            2:       begin gap_pct = 0;  stall_pct = 46; end
            3:       begin gap_pct = 15; stall_pct = 15; end
            default: begin gap_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    task automatic add_cmd(input logic [OPCODE_W-1:0] op, input logic [FRAME_W-1:0] fr,
                           input logic [STATUS_W-1:0] st, input logic [FRAME_W-1:0] ef,
                           input logic [REFCNT_W-1:0] ec);
        t_step s;
        s.is_reg = 1'b0;
        s.op     = op;
        s.idx    = CFG_TOTAL;
        s.arg    = CFG_DATA_W'(fr);
        s.res    = '{st, ef, ec};
        dir_tab.push_back(s);
    endtask

    task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        t_step s;
        s.is_reg = 1'b1;
        s.op     = OP_INIT;
        s.idx    = idx;
        s.arg    = val;
        s.res    = '0;
        dir_tab.push_back(s);
    endtask

    // one register setting, an init, then random commands aimed mostly at the
    // top of the range (where the list head lives) and at the reserved frames
    task automatic random_phase(input int unsigned tot, input int unsigned res,
                                input int unsigned skp, input bit en,
                                input int n, input int mode);
        int unsigned lim;
        int unsigned w;
        int unsigned pick;
        int unsigned roll;
        logic [OPCODE_W-1:0] op;
        logic [FRAME_W-1:0]  fr;
        write_reg(CFG_TOTAL, CFG_DATA_W'(tot));
        write_reg(CFG_RESERVED, CFG_DATA_W'(res));
        write_reg(CFG_SKIP, CFG_DATA_W'(skp));
        write_reg(CFG_SKIP_EN, CFG_DATA_W'(en));
        set_idling(mode);
        lim = ((tot > FRAMES) ? FRAMES : tot) - 1;
        w   = (lim < 31) ? lim : 31;
        push_cmd(OP_INIT, FRAME_W'($urandom), 1'b0, '0);
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(999);
            if (roll < 5)        op = OP_INIT;
            else if (roll < 255) op = OP_ALLOC;
            else if (roll < 450) op = OP_FREE;
            else if (roll < 650) op = OP_INCREF;
            else if (roll < 850) op = OP_DECREF;
            else if (roll < 970) op = OP_READ;
            else if (roll < 985) op = OP_SPARE6;
            else                 op = OP_SPARE7;
            pick = $urandom_range(99);
            if (pick < 40)      fr = FRAME_W'(lim - $urandom_range(w, 0));
            else if (pick < 60) fr = FRAME_W'($urandom_range(w, 0));
            else if (pick < 90) fr = FRAME_W'($urandom_range(lim, 0));
            else                fr = FRAME_W'($urandom);
            push_cmd(op, fr, 1'b0, '0);
            // let the block run dry once per phase
            if (i == n / 2) settle();
        end
    endtask

    // -------------------------------------------------------------------- test

    initial begin
        // reset register values: 16384 frames, none reserved, no skip
        add_cmd(OP_ALLOC,  14'h0000, ST_NO_FREE,   14'h0000, 16'd0);  // alloc before init
        add_cmd(OP_INIT,   14'h3FFF, ST_OK,        14'h3FFF, 16'd0);
        add_cmd(OP_ALLOC,  14'h0000, ST_OK,        14'h3FFF, 16'd0);  // highest frame first
        add_cmd(OP_INCREF, 14'h3FFF, ST_OK,        14'h3FFF, 16'd1);
        add_cmd(OP_DECREF, 14'h3FFF, ST_OK,        14'h3FFF, 16'd0);  // drops to zero, pushed
        add_cmd(OP_FREE,   14'h3FFF, ST_DBL_FREE,  14'h3FFF, 16'd0);
        add_cmd(OP_DECREF, 14'h3FFF, ST_LIMIT,     14'h3FFF, 16'd0);  // underflow
        add_cmd(OP_SPARE6, 14'h1555, ST_OK,        14'h1555, 16'd0);
        add_cmd(OP_SPARE7, 14'h2AAA, ST_OK,        14'h2AAA, 16'd0);
        // 8 frames, 0..2 reserved, frame 5 kept off the list
        add_reg(CFG_TOTAL, 15'd8);
        add_reg(CFG_RESERVED, 15'd3);
        add_reg(CFG_SKIP, 15'd5);
        add_reg(CFG_SKIP_EN, 15'd1);
        add_cmd(OP_INIT,   14'h0000, ST_OK,        14'h0000, 16'd0);
        add_cmd(OP_READ,   14'h0002, ST_OK,        14'h0002, 16'd1);
        add_cmd(OP_READ,   14'h0008, ST_BAD_FRAME, 14'h0008, 16'd0);
        add_cmd(OP_INCREF, 14'h3FFF, ST_BAD_FRAME, 14'h3FFF, 16'd0);
        add_cmd(OP_ALLOC,  14'h0000, ST_OK,        14'h0007, 16'd0);
        add_cmd(OP_ALLOC,  14'h0000, ST_OK,        14'h0006, 16'd0);
        add_cmd(OP_ALLOC,  14'h0000, ST_OK,        14'h0004, 16'd0);  // 5 skipped
        add_cmd(OP_ALLOC,  14'h0000, ST_OK,        14'h0003, 16'd0);
        add_cmd(OP_ALLOC,  14'h0000, ST_NO_FREE,   14'h0000, 16'd0);
        add_cmd(OP_FREE,   14'h0005, ST_OK,        14'h0005, 16'd0);  // skipped frame joins
        add_cmd(OP_ALLOC,  14'h0000, ST_OK,        14'h0005, 16'd0);
        add_cmd(OP_DECREF, 14'h0000, ST_OK,        14'h0000, 16'd0);  // reserved frame freed
        add_cmd(OP_FREE,   14'h0001, ST_OK,        14'h0001, 16'd1);  // still referenced
        add_cmd(OP_INCREF, 14'h0000, ST_OK,        14'h0000, 16'd1);  // frame is on the list
        add_cmd(OP_DECREF, 14'h0000, ST_DBL_FREE,  14'h0000, 16'd0);  // no second push
        add_cmd(OP_ALLOC,  14'h0000, ST_OK,        14'h0000, 16'd0);

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_reg)
                write_reg(dir_tab[i].idx, dir_tab[i].arg);
            else
                push_cmd(dir_tab[i].op, dir_tab[i].arg[FRAME_W-1:0], 1'b1, dir_tab[i].res);
        end

        // run one count up by twenty, then back down by three
        write_reg(CFG_TOTAL, 15'd16);
        write_reg(CFG_RESERVED, 15'd0);
        write_reg(CFG_SKIP, 15'd0);
        write_reg(CFG_SKIP_EN, 15'd0);
        push_cmd(OP_INIT, 14'h0000, 1'b0, '0);
        repeat (20) push_cmd(OP_INCREF, 14'd10, 1'b0, '0);
        repeat (3) push_cmd(OP_DECREF, 14'd10, 1'b0, '0);

        random_phase(16384, 0,     0,     1'b0, 250, 0);
        random_phase(8,     3,     5,     1'b1, 250, 1);
        random_phase(1,     0,     0,     1'b1, 250, 2);  // only frame is skipped
        random_phase(20,    25,    3,     1'b1, 250, 3);  // reserved beyond total
        random_phase(16384, 16384, 16383, 1'b1, 250, 0);  // everything reserved
        random_phase(48,    6,     2,     1'b1, 250, 1);  // skip inside reserved
        random_phase(3000,  40,    2999,  1'b1, 250, 2);
        random_phase(1,     1,     0,     1'b0, 250, 3);

        cmd_valid = 1'b0;
        while (due_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (mismatches == 0)
            $display("[page_frame_allocator_refcount_core] OK");
        else
            $display("[page_frame_allocator_refcount_core] ERROR");
        $finish;
    end

endmodule
